// File: src/obm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_pkg
// Shared types, constants and the priority compare of the order book matcher.
// ----------------------------------------------------------------------------
package obm_pkg;

	localparam int BOOK_DEPTH = 16;
	localparam int AW         = $clog2(BOOK_DEPTH);
	localparam int CW         = $clog2(BOOK_DEPTH + 1);
	localparam int PRICE_W    = 40;
	localparam int AMT_W      = 40;
	localparam int TS_W       = 48;
	localparam int TOL_W      = 21;
	localparam int ENTRY_W    = PRICE_W + AMT_W + TS_W;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [AMT_W-1:0]   amount;
		logic [TS_W-1:0]    ts;
	} entry_t;

	typedef enum logic [1:0] {
		KIND_ADD_OK   = 2'd0,
		KIND_ADD_FULL = 2'd1,
		KIND_FILL     = 2'd2,
		KIND_DONE     = 2'd3
	} kind_t;

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_MATCH = 1'b1
	} cmd_t;

	typedef enum logic {
		SIDE_BUY  = 1'b0,
		SIDE_SELL = 1'b1
	} side_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_INS_CMP,
		ST_MB_CHK,
		ST_MB_LD,
		ST_MS_CHK,
		ST_MS_CMP,
		ST_CP_CHK,
		ST_CP_WR,
		ST_SRT_CHK,
		ST_SRT_LD
	} state_t;

	// true when a has priority over b
	function automatic logic ahead(entry_t a, entry_t b, logic is_sell);
		logic r;
		if (a.price != b.price)
			r = is_sell ? (a.price < b.price) : (a.price > b.price);
		else if (a.ts != b.ts)
			r = a.ts < b.ts;
		else
			r = a.amount < b.amount;
		return r;
	endfunction

endpackage

// File: src/obm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module obm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/order_book_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_matcher
// Price-time priority limit order book for one product with a match sweep.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. command selects add
//   (side, price, amount, timestamp) or a match sweep over both books.
//   Results appear for one cycle with result_strobe high; the receiver cannot
//   stall and every result must be taken as shown.
//   Add: one result (accepted or book full) with last set. A full book answers
//   without raising busy; an insertion holds busy while it shifts entries.
//   Match: one fill per nonzero trade, then a done item with last set. The
//   sweep visits every buy/sell pair, then compacts each book (dropping
//   zero amounts) and re-sorts it by reinsertion, all through one RAM port
//   pair per book. cfg_write loads price_tolerance; the user must write it
//   only while the block is idle, as the block itself does not enforce it.
//   Reset empties both books and sets the tolerance to 1; book RAM contents
//   are not cleared, and entries at or above the counts are never used.
// ----------------------------------------------------------------------------
module order_book_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic        side,
	input  logic [39:0] price,
	input  logic [39:0] amount,
	input  logic [47:0] timestamp,
	input  logic        cfg_write,
	input  logic [20:0] cfg_data,
	output logic        result_strobe,
	output logic [1:0]  kind,
	output logic [39:0] fill_price,
	output logic [39:0] fill_amount,
	output logic [47:0] fill_time,
	output logic [4:0]  buy_count,
	output logic [4:0]  sell_count,
	output logic        last
);

	obm_pkg::state_t state_q, state_d;

	logic [obm_pkg::TOL_W-1:0] tol_q;
	logic [obm_pkg::CW-1:0]    buy_cnt_q, sell_cnt_q;
	logic [obm_pkg::CW-1:0]    i_q, j_q, k_q, h_q;
	logic                      side_q, sort_mode_q;
	obm_pkg::entry_t           e_q, bq_q;

	logic                      strobe_q;
	obm_pkg::kind_t            kind_q;
	logic [39:0]               fprice_q, famt_q;
	logic [47:0]               ftime_q;
	logic                      last_q;

	logic                      buy_we, sell_we;
	logic [obm_pkg::AW-1:0]    buy_waddr, sell_waddr, buy_raddr, sell_raddr;
	obm_pkg::entry_t           buy_wdata, sell_wdata, buy_rdata, sell_rdata;

	logic                      emit;
	obm_pkg::kind_t            emit_kind;
	logic                      emit_last;

	obm_pkg::entry_t           rd_sel;
	logic [obm_pkg::CW-1:0]    side_cnt, in_cnt, h_m1;
	logic                      accept, in_full, ins_ahead;
	logic [39:0]               pdiff, m_amt;
	logic                      pmatch;
	obm_pkg::entry_t           s_new;

	obm_ram #(.WIDTH(obm_pkg::ENTRY_W), .DEPTH(obm_pkg::BOOK_DEPTH)) u_buy_ram (
		.clk(clk), .we(buy_we), .waddr(buy_waddr), .wdata(buy_wdata),
		.raddr(buy_raddr), .rdata(buy_rdata)
	);

	obm_ram #(.WIDTH(obm_pkg::ENTRY_W), .DEPTH(obm_pkg::BOOK_DEPTH)) u_sell_ram (
		.clk(clk), .we(sell_we), .waddr(sell_waddr), .wdata(sell_wdata),
		.raddr(sell_raddr), .rdata(sell_rdata)
	);

	assign busy     = (state_q != obm_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign in_cnt   = (side == obm_pkg::SIDE_SELL) ? sell_cnt_q : buy_cnt_q;
	assign in_full  = (in_cnt >= obm_pkg::CW'(obm_pkg::BOOK_DEPTH));
	assign side_cnt = side_q ? sell_cnt_q : buy_cnt_q;
	assign rd_sel   = side_q ? sell_rdata : buy_rdata;
	assign h_m1     = h_q - 1'b1;
	assign ins_ahead = obm_pkg::ahead(e_q, rd_sel, side_q);

	assign pdiff  = (bq_q.price >= sell_rdata.price) ? (bq_q.price - sell_rdata.price)
	                                                 : (sell_rdata.price - bq_q.price);
	assign pmatch = (pdiff < {19'd0, tol_q});
	assign m_amt  = !pmatch ? 40'd0
	              : (bq_q.amount < sell_rdata.amount) ? bq_q.amount : sell_rdata.amount;

	always_comb begin
		s_new        = sell_rdata;
		s_new.amount = sell_rdata.amount - m_amt;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			obm_pkg::ST_IDLE: begin
				if (accept) begin
					if (command == obm_pkg::CMD_MATCH)
						state_d = obm_pkg::ST_MB_CHK;
					else if (!in_full)
						state_d = obm_pkg::ST_INS_CHK;
				end
			end
			obm_pkg::ST_INS_CHK: begin
				if (h_q == '0)
					state_d = sort_mode_q ? obm_pkg::ST_SRT_CHK : obm_pkg::ST_IDLE;
				else
					state_d = obm_pkg::ST_INS_CMP;
			end
			obm_pkg::ST_INS_CMP: begin
				if (ins_ahead)
					state_d = obm_pkg::ST_INS_CHK;
				else
					state_d = sort_mode_q ? obm_pkg::ST_SRT_CHK : obm_pkg::ST_IDLE;
			end
			obm_pkg::ST_MB_CHK: begin
				state_d = (i_q == buy_cnt_q) ? obm_pkg::ST_CP_CHK : obm_pkg::ST_MB_LD;
			end
			obm_pkg::ST_MB_LD:  state_d = obm_pkg::ST_MS_CHK;
			obm_pkg::ST_MS_CHK: begin
				state_d = (j_q == sell_cnt_q) ? obm_pkg::ST_MB_CHK : obm_pkg::ST_MS_CMP;
			end
			obm_pkg::ST_MS_CMP: state_d = obm_pkg::ST_MS_CHK;
			obm_pkg::ST_CP_CHK: begin
				state_d = (i_q == side_cnt) ? obm_pkg::ST_SRT_CHK : obm_pkg::ST_CP_WR;
			end
			obm_pkg::ST_CP_WR:  state_d = obm_pkg::ST_CP_CHK;
			obm_pkg::ST_SRT_CHK: begin
				if (i_q >= side_cnt)
					state_d = side_q ? obm_pkg::ST_IDLE : obm_pkg::ST_CP_CHK;
				else
					state_d = obm_pkg::ST_SRT_LD;
			end
			obm_pkg::ST_SRT_LD: state_d = obm_pkg::ST_INS_CHK;
			default:            state_d = obm_pkg::ST_IDLE;
		endcase
	end

	// RAM controls and result emission
	always_comb begin
		buy_we     = 1'b0;
		sell_we    = 1'b0;
		buy_waddr  = '0;
		sell_waddr = '0;
		buy_wdata  = e_q;
		sell_wdata = e_q;
		buy_raddr  = '0;
		sell_raddr = '0;
		emit       = 1'b0;
		emit_kind  = obm_pkg::KIND_ADD_OK;
		emit_last  = 1'b1;
		unique case (state_q)
			obm_pkg::ST_IDLE: begin
				if (accept && command == obm_pkg::CMD_ADD && in_full) begin
					emit      = 1'b1;
					emit_kind = obm_pkg::KIND_ADD_FULL;
				end
			end
			obm_pkg::ST_INS_CHK: begin
				if (h_q == '0) begin
					buy_we  = !side_q;
					sell_we = side_q;
					emit    = !sort_mode_q;
				end else begin
					buy_raddr  = h_m1[obm_pkg::AW-1:0];
					sell_raddr = h_m1[obm_pkg::AW-1:0];
				end
			end
			obm_pkg::ST_INS_CMP: begin
				buy_we     = !side_q;
				sell_we    = side_q;
				buy_waddr  = h_q[obm_pkg::AW-1:0];
				sell_waddr = h_q[obm_pkg::AW-1:0];
				if (ins_ahead) begin
					buy_wdata  = rd_sel;
					sell_wdata = rd_sel;
				end else begin
					emit = !sort_mode_q;
				end
			end
			obm_pkg::ST_MB_CHK: begin
				buy_raddr = i_q[obm_pkg::AW-1:0];
			end
			obm_pkg::ST_MB_LD: ;
			obm_pkg::ST_MS_CHK: begin
				sell_raddr = j_q[obm_pkg::AW-1:0];
				if (j_q == sell_cnt_q) begin
					buy_we    = 1'b1;
					buy_waddr = i_q[obm_pkg::AW-1:0];
					buy_wdata = bq_q;
				end
			end
			obm_pkg::ST_MS_CMP: begin
				sell_we    = 1'b1;
				sell_waddr = j_q[obm_pkg::AW-1:0];
				sell_wdata = s_new;
				if (m_amt != '0) begin
					emit      = 1'b1;
					emit_kind = obm_pkg::KIND_FILL;
					emit_last = 1'b0;
				end
			end
			obm_pkg::ST_CP_CHK, obm_pkg::ST_SRT_CHK: begin
				buy_raddr  = i_q[obm_pkg::AW-1:0];
				sell_raddr = i_q[obm_pkg::AW-1:0];
				if (state_q == obm_pkg::ST_SRT_CHK && i_q >= side_cnt && side_q) begin
					emit      = 1'b1;
					emit_kind = obm_pkg::KIND_DONE;
				end
			end
			obm_pkg::ST_CP_WR: begin
				if (rd_sel.amount != '0) begin
					buy_we     = !side_q;
					sell_we    = side_q;
					buy_waddr  = k_q[obm_pkg::AW-1:0];
					sell_waddr = k_q[obm_pkg::AW-1:0];
					buy_wdata  = rd_sel;
					sell_wdata = rd_sel;
				end
			end
			obm_pkg::ST_SRT_LD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= obm_pkg::ST_IDLE;
			tol_q      <= obm_pkg::TOL_W'(1);
			buy_cnt_q  <= '0;
			sell_cnt_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (cfg_write)
				tol_q <= cfg_data;
			if ((state_q == obm_pkg::ST_INS_CHK && h_q == '0 && !sort_mode_q) ||
			    (state_q == obm_pkg::ST_INS_CMP && !ins_ahead && !sort_mode_q)) begin
				if (side_q)
					sell_cnt_q <= sell_cnt_q + 1'b1;
				else
					buy_cnt_q <= buy_cnt_q + 1'b1;
			end
			if (state_q == obm_pkg::ST_CP_CHK && i_q == side_cnt) begin
				if (side_q)
					sell_cnt_q <= k_q;
				else
					buy_cnt_q <= k_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q   <= emit_kind;
			last_q   <= emit_last;
			fprice_q <= (emit_kind == obm_pkg::KIND_FILL) ? bq_q.price : 40'd0;
			famt_q   <= (emit_kind == obm_pkg::KIND_FILL) ? m_amt : 40'd0;
			ftime_q  <= (emit_kind == obm_pkg::KIND_FILL) ? bq_q.ts : 48'd0;
		end
		unique case (state_q)
			obm_pkg::ST_IDLE: begin
				if (accept) begin
					side_q       <= side;
					sort_mode_q  <= 1'b0;
					h_q          <= in_cnt;
					i_q          <= '0;
					e_q.price    <= price;
					e_q.amount   <= amount;
					e_q.ts       <= timestamp;
				end
			end
			obm_pkg::ST_INS_CHK: begin
				if (h_q == '0)
					i_q <= i_q + 1'b1;
			end
			obm_pkg::ST_INS_CMP: begin
				if (ins_ahead)
					h_q <= h_m1;
				else
					i_q <= i_q + 1'b1;
			end
			obm_pkg::ST_MB_CHK: begin
				if (i_q == buy_cnt_q) begin
					side_q <= obm_pkg::SIDE_BUY;
					i_q    <= '0;
					k_q    <= '0;
				end
			end
			obm_pkg::ST_MB_LD: begin
				bq_q <= buy_rdata;
				j_q  <= '0;
			end
			obm_pkg::ST_MS_CHK: begin
				if (j_q == sell_cnt_q)
					i_q <= i_q + 1'b1;
			end
			obm_pkg::ST_MS_CMP: begin
				bq_q.amount <= bq_q.amount - m_amt;
				j_q         <= j_q + 1'b1;
			end
			obm_pkg::ST_CP_CHK: begin
				if (i_q == side_cnt)
					i_q <= obm_pkg::CW'(1);
			end
			obm_pkg::ST_CP_WR: begin
				i_q <= i_q + 1'b1;
				if (rd_sel.amount != '0)
					k_q <= k_q + 1'b1;
			end
			obm_pkg::ST_SRT_CHK: begin
				if (i_q >= side_cnt && !side_q) begin
					side_q <= obm_pkg::SIDE_SELL;
					i_q    <= '0;
					k_q    <= '0;
				end
			end
			obm_pkg::ST_SRT_LD: begin
				e_q         <= rd_sel;
				h_q         <= i_q;
				sort_mode_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign result_strobe = strobe_q;
	assign kind          = kind_q;
	assign fill_price    = fprice_q;
	assign fill_amount   = famt_q;
	assign fill_time     = ftime_q;
	assign last          = last_q;
	assign buy_count     = 5'(buy_cnt_q);
	assign sell_count    = 5'(sell_cnt_q);

endmodule

// File: tb/order_book_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_matcher_tb
// Self-checking bench for the order book matcher: a local model of both
// sorted books predicts every add, fill and done item; directed tests cover
// book full, zero amounts, tolerance extremes and tie ordering, then random
// order flow with random match sweeps under several tolerances.
// ----------------------------------------------------------------------------
module order_book_matcher_tb;

	typedef struct {
		logic [1:0]  kind;
		logic [39:0] fprice;
		logic [39:0] famount;
		logic [47:0] ftime;
		logic [4:0]  nbuy;
		logic [4:0]  nsell;
		logic        lst;
	} book_result_t;

	typedef struct {
		logic [39:0] price;
		logic [39:0] amount;
		logic [47:0] ts;
	} order_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic        side;
	logic [39:0] price;
	logic [39:0] amount;
	logic [47:0] timestamp;
	logic        cfg_write;
	logic [20:0] cfg_data;
	logic        result_strobe;
	logic [1:0]  kind;
	logic [39:0] fill_price;
	logic [39:0] fill_amount;
	logic [47:0] fill_time;
	logic [4:0]  buy_count;
	logic [4:0]  sell_count;
	logic        last;

	order_t       bids[$];
	order_t       asks[$];
	logic [20:0]  tolerance;
	book_result_t pending_results[$];
	int           mismatches;
	int           fills_seen;
	int           items_sent;
	int           matches_sent;
	longint       cycle_count;
	bit           no_gaps;

	order_book_matcher DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .side(side), .price(price), .amount(amount),
		.timestamp(timestamp), .cfg_write(cfg_write), .cfg_data(cfg_data),
		.result_strobe(result_strobe), .kind(kind), .fill_price(fill_price),
		.fill_amount(fill_amount), .fill_time(fill_time), .buy_count(buy_count),
		.sell_count(sell_count), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit has_priority(order_t a, order_t b, bit sell);
		if (a.price != b.price)
			return sell ? (a.price < b.price) : (a.price > b.price);
		if (a.ts != b.ts)
			return a.ts < b.ts;
		return a.amount < b.amount;
	endfunction

	function automatic book_result_t make_result(obm_pkg::kind_t k, logic [39:0] p,
			logic [39:0] a, logic [47:0] t, logic l);
		book_result_t r;
		r.kind = k;
		r.fprice = p;
		r.famount = a;
		r.ftime = t;
		r.nbuy = 5'(bids.size());
		r.nsell = 5'(asks.size());
		r.lst = l;
		return r;
	endfunction

	function automatic void expect_result(book_result_t r);
		pending_results = {pending_results, r};
	endfunction

	task automatic insert_sorted(ref order_t bk[$], input order_t o, input bit sell);
		int pos;
		pos = 0;
		while (pos < bk.size() && !has_priority(o, bk[pos], sell))
			pos++;
		bk.insert(pos, o);
	endtask

	task automatic resort(ref order_t bk[$], input bit sell);
		order_t kept[$];
		kept = {};
		foreach (bk[i])
			if (bk[i].amount != 0)
				insert_sorted(kept, bk[i], sell);
		bk = kept;
	endtask

	task automatic predict_item(obm_pkg::cmd_t cmd, obm_pkg::side_t sd, logic [39:0] p,
			logic [39:0] a, logic [47:0] t);
		order_t       o;
		logic [39:0]  d;
		logic [39:0]  m;
		int           n;
		if (cmd == obm_pkg::CMD_ADD) begin
			o.price = p;
			o.amount = a;
			o.ts = t;
			if (sd == obm_pkg::SIDE_SELL ? asks.size() >= obm_pkg::BOOK_DEPTH
					: bids.size() >= obm_pkg::BOOK_DEPTH) begin
				expect_result(make_result(obm_pkg::KIND_ADD_FULL, 40'd0, 40'd0, 48'd0,
					1'b1));
			end else begin
				if (sd == obm_pkg::SIDE_SELL)
					insert_sorted(asks, o, 1'b1);
				else
					insert_sorted(bids, o, 1'b0);
				expect_result(make_result(obm_pkg::KIND_ADD_OK, 40'd0, 40'd0, 48'd0,
					1'b1));
			end
		end else begin
			n = 0;
			foreach (bids[i])
				foreach (asks[j]) begin
					d = bids[i].price >= asks[j].price ? bids[i].price - asks[j].price
						: asks[j].price - bids[i].price;
					if (d < {19'd0, tolerance}) begin
						m = bids[i].amount < asks[j].amount ? bids[i].amount : asks[j].amount;
						bids[i].amount -= m;
						asks[j].amount -= m;
						if (m != 0 && n < 2 * obm_pkg::BOOK_DEPTH) begin
							expect_result(make_result(obm_pkg::KIND_FILL, bids[i].price, m,
								bids[i].ts, 1'b0));
							n++;
						end
					end
				end
			resort(bids, 1'b0);
			resort(asks, 1'b1);
			expect_result(make_result(obm_pkg::KIND_DONE, 40'd0, 40'd0, 48'd0, 1'b1));
		end
	endtask

	task automatic send_item(obm_pkg::cmd_t cmd, obm_pkg::side_t sd, logic [39:0] p,
			logic [39:0] a, logic [47:0] t);
		if (!no_gaps)
			while ($urandom_range(99) < 10) begin
				start <= 1'b0;
				@(negedge clk);
			end
		command <= cmd;
		side <= sd;
		price <= p;
		amount <= a;
		timestamp <= t;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_item(cmd, sd, p, a, t);
		items_sent++;
		if (cmd == obm_pkg::CMD_MATCH)
			matches_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_tolerance(logic [20:0] v);
		drain();
		cfg_data <= v;
		cfg_write <= 1'b1;
		@(negedge clk);
		cfg_write <= 1'b0;
		tolerance = v;
	endtask

	task automatic add_order(obm_pkg::side_t sd, logic [39:0] p, logic [39:0] a,
			logic [47:0] t);
		send_item(obm_pkg::CMD_ADD, sd, p, a, t);
	endtask

	task automatic run_match();
		send_item(obm_pkg::CMD_MATCH, obm_pkg::side_t'($urandom_range(1)),
			40'({$urandom, $urandom}), 40'({$urandom, $urandom}),
			48'({$urandom, $urandom}));
	endtask

	// reset tolerance 1: only equal prices trade; ties and zero amounts
	task automatic test_exact_match();
		add_order(obm_pkg::SIDE_BUY, 40'd1000, 40'd50, 48'd7);
		add_order(obm_pkg::SIDE_BUY, 40'd1000, 40'd30, 48'd7);
		add_order(obm_pkg::SIDE_BUY, 40'd1000, 40'd0, 48'd3);
		add_order(obm_pkg::SIDE_SELL, 40'd1000, 40'd60, 48'd9);
		add_order(obm_pkg::SIDE_SELL, 40'd1001, 40'd10, 48'd1);
		add_order(obm_pkg::SIDE_SELL, 40'd999, 40'd0, 48'd2);
		run_match();
		run_match();
	endtask

	task automatic test_book_full();
		for (int i = 0; i < obm_pkg::BOOK_DEPTH + 2; i++)
			add_order(obm_pkg::SIDE_SELL, 40'hFF_FFFF_FFFF - 40'(i),
				i == 0 ? 40'hFF_FFFF_FFFF : 40'(i), 48'hFFFF_FFFF_FFFF - 48'(i));
		for (int i = 0; i < obm_pkg::BOOK_DEPTH + 1; i++)
			add_order(obm_pkg::SIDE_BUY, 40'hFF_FFFF_FFF0 + 40'(i % 4),
				40'd1 << (i % 40), 48'(i));
		run_match();
		run_match();
	endtask

	task automatic test_tolerance_extremes();
		write_tolerance(21'd0);
		add_order(obm_pkg::SIDE_BUY, 40'd5000, 40'd10, 48'd0);
		add_order(obm_pkg::SIDE_SELL, 40'd5000, 40'd10, 48'd0);
		run_match();
		write_tolerance(21'h1F_FFFF);
		add_order(obm_pkg::SIDE_BUY, 40'd0, 40'd4, 48'd1);
		add_order(obm_pkg::SIDE_SELL, 40'd2000000, 40'd3, 48'd2);
		run_match();
		write_tolerance(21'h10_0000);
		run_match();
	endtask

	task automatic test_random_flow();
		logic [39:0] base;
		int          burst;
		for (int k = 0; k < 6; k++) begin
			write_tolerance(k == 5 ? 21'd1 : 21'($urandom_range(1, 1 << (4 * k))));
			base = 40'({$urandom, $urandom});
			for (int i = 0; i < 44; i++) begin
				no_gaps = (k == 2);
				burst = $urandom_range(99);
				if (burst < 12)
					run_match();
				else if (burst < 16)
					add_order(obm_pkg::side_t'($urandom_range(1)),
						40'({$urandom, $urandom}), 40'({$urandom, $urandom}),
						48'({$urandom, $urandom}));
				else
					add_order(obm_pkg::side_t'($urandom_range(1)),
						base + 40'($urandom_range(40)),
						$urandom_range(3) == 0 ? 40'd0 : 40'($urandom_range(1, 300)),
						48'($urandom_range(50)));
			end
			no_gaps = 1'b0;
			run_match();
		end
	endtask

	always @(posedge clk) begin
		book_result_t e;
		cycle_count++;
		if (result_strobe) begin
			if (kind == obm_pkg::KIND_FILL)
				fills_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected item kind %0d", kind);
			end else begin
				e = pending_results.pop_front();
				if (e.kind !== kind || e.fprice !== fill_price || e.famount !== fill_amount
						|| e.ftime !== fill_time || e.nbuy !== buy_count
						|| e.nsell !== sell_count || e.lst !== last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: exp k%0d p%h a%h t%h b%0d s%0d l%0d",
							e.kind, e.fprice, e.famount, e.ftime, e.nbuy, e.nsell, e.lst);
						$display("       got k%0d p%h a%h t%h b%0d s%0d l%0d",
							kind, fill_price, fill_amount, fill_time, buy_count, sell_count,
							last);
					end
				end
			end
		end
	end

	initial begin
		if (cycle_count >= 0) begin
			wait (cycle_count >= 2000000);
			$display("ERROR: timeout");
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		fills_seen = 0;
		items_sent = 0;
		matches_sent = 0;
		cycle_count = 0;
		no_gaps = 1'b0;
		tolerance = 21'd1;
		arst_n = 1'b0;
		start = 1'b0;
		command = 1'b0;
		side = 1'b0;
		price = '0;
		amount = '0;
		timestamp = '0;
		cfg_write = 1'b0;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_exact_match();
		test_book_full();
		test_tolerance_extremes();
		test_random_flow();
		drain();
		if (pending_results.size() != 0)
			mismatches++;
		$display("Sent %0d items (%0d match sweeps), checked %0d fills.",
			items_sent, matches_sent, fills_seen);
		$display("Tolerances covered 0, 1, mid values and the 21-bit maximum.");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
